>>> rtl/ase_pkg.sv
package ase_pkg;

	// Number of values one set can hold; later values of a full set are dropped.
	localparam int unsigned SORT_DEPTH = 32;

	localparam int unsigned VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Control that the top level broadcasts to every cell of the chain.
	typedef struct packed {
		logic insert;   // place the broadcast value into the sorted row
		logic shift;    // move the whole row one cell toward the output
	} cell_ctl_t;

endpackage

>>> rtl/ase_cell.sv
module ase_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ase_pkg::cell_ctl_t  ctl,
	input  ase_pkg::value_t     new_value,
	input  logic                left_valid,
	input  ase_pkg::value_t     left_value,
	input  logic                left_greater,
	input  logic                right_valid,
	input  ase_pkg::value_t     right_value,
	output logic                valid,
	output ase_pkg::value_t     value,
	output logic                greater
);

	logic            valid_q;
	ase_pkg::value_t value_q;

	// Strict compare keeps equal values in arrival order.
	assign greater = valid_q && (value_q > new_value);
	assign valid   = valid_q;
	assign value   = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.insert) begin
			if (left_greater || greater || (!valid_q && left_valid)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right_value;
		end else if (ctl.insert) begin
			if (left_greater) begin
				value_q <= left_value;
			end else if (greater || (!valid_q && left_valid)) begin
				value_q <= new_value;
			end
		end
	end

endmodule

>>> rtl/ascending_sort_engine.sv
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, item_value, last_item | into block
// output   | out_valid, out_stall, sorted_value,       | out of block
//          | last_result, overflow                     |
//
// Loading: the chain of cells places each value in its sorted position in
// the cycle it is accepted.
// After the item marked last, the set drains from the head cell, one result
// per cycle while the output is not stalled; input is stalled for the whole
// drain.
// Reset clears every cell's valid bit, the drain flag and the overflow flag;
// stored values are not cleared. An output stall freezes the draining chain.
module ascending_sort_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ase_pkg::value_t     item_value,
	input  logic                last_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ase_pkg::value_t     sorted_value,
	output logic                last_result,
	output logic                overflow
);

	localparam int unsigned DEPTH = ase_pkg::SORT_DEPTH;
	localparam logic [DEPTH-1:0] VEC_ONE = {{(DEPTH-1){1'b0}}, 1'b1};

	logic               drain_q;
	logic               dropped_q;
	logic               in_accept;
	logic               out_accept;
	logic               full;
	ase_pkg::cell_ctl_t ctl;

	logic [DEPTH-1:0]   cell_valid;
	logic [DEPTH-1:0]   cell_greater;
	ase_pkg::value_t    cell_value [DEPTH];

	// The row is full once the tail cell holds a value.
	assign full       = cell_valid[DEPTH-1];
	assign in_stall   = drain_q;
	assign in_accept  = in_valid && !drain_q;

	// The head cell is the output register; the rest of the row is the queue
	// behind it.
	assign out_valid    = drain_q && cell_valid[0];
	assign sorted_value = cell_value[0];
	assign last_result  = !cell_valid[1];
	assign overflow     = dropped_q;
	assign out_accept   = out_valid && !out_stall;

	assign ctl.insert = in_accept && !full;
	assign ctl.shift  = out_accept;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic            left_valid;
			ase_pkg::value_t left_value;
			logic            left_greater;
			logic            right_valid;
			ase_pkg::value_t right_value;

			if (gi == 0) begin : g_head
				// The head has no left neighbor; the missing neighbor always counts as filled.
				assign left_valid   = 1'b1;
				assign left_value   = item_value;
				assign left_greater = 1'b0;
			end else begin : g_body
				assign left_valid   = cell_valid[gi-1];
				assign left_value   = cell_value[gi-1];
				assign left_greater = cell_greater[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_valid = 1'b0;
				assign right_value = '0;
			end else begin : g_inner
				assign right_valid = cell_valid[gi+1];
				assign right_value = cell_value[gi+1];
			end

			ase_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl),
				.new_value    (item_value),
				.left_valid   (left_valid),
				.left_value   (left_value),
				.left_greater (left_greater),
				.right_valid  (right_valid),
				.right_value  (right_value),
				.valid        (cell_valid[gi]),
				.value        (cell_value[gi]),
				.greater      (cell_greater[gi])
			);
		end
	endgenerate

	// Draining starts after the item marked last has been accepted and ends
	// when the final result is taken, which also empties the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (out_accept && last_result) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (in_accept) begin
			if (last_item) begin
				drain_q <= 1'b1;
			end
			if (full) begin
				dropped_q <= 1'b1;
			end
		end
	end

	// Filled cells always form an unbroken run from the head.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + VEC_ONE) & cell_valid) == '0)
		else $error("cell valid bits are not a prefix");

	// While draining, the head cell holds a result.
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> cell_valid[0])
		else $error("drain without a value at the head");

	// Each insertion adds exactly one value to the row.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
		else $error("insertion did not add one value");

	// Taking the final result leaves the row empty.
	a_set_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && last_result) |=> (cell_valid == '0) && !out_valid)
		else $error("row not empty after final result");

endmodule
